[sv/gnta_pkg.sv]
package gnta_pkg;

  localparam int unsigned DT_SCALE = 1000000;
  localparam int unsigned DT_HALF = 500000;
  localparam int unsigned REM_W = 20;

  localparam logic [1:0] ST_FRAME = 2'd0;
  localparam logic [1:0] ST_UPDATE = 2'd1;
  localparam logic [1:0] ST_CREATE = 2'd2;
  localparam logic [1:0] ST_DROP = 2'd3;

  typedef struct packed {
    logic start;
    logic short_mode;
  } div_req_t;

endpackage

[sv/gated_nearest_track_association.sv]
// Track association block with a table of tracks held in one synchronous memory.
// The input channel (in_valid, in_stall) takes frame items (in_kind 0) and sensor
// object items (in_kind 1); each item yields exactly one result transfer on the
// output channel (out_valid, out_stall). The user writes gate factors through
// cfg_we, cfg_index and cfg_data while the block is idle; the block does not
// enforce this. A frame item divides the elapsed time by 1e6, then walks each
// valid track, with a further rounding division for each axis that moves and
// needs it.
// An object item walks every valid track through one shared 33x33 multiplier,
// then runs the gate check and a write-back; on an empty table it goes straight
// to the write-back. The next item is taken in the cycle after the result is
// registered.
// One item is worked on at a time; a new item is taken once the previous result
// sits in the output register. If the receiver stalls, the result is held and
// the next item is worked on but not finished until that transfer completes.
// Reset empties the table, clears the id counter and the last frame time, and
// sets all gate factors to 1.0; no memory clearing pass is needed.
module gated_nearest_track_association #(
  parameter int MAX_TRACKS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [63:0] in_frame_time,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [4:0]  out_track_slot,
  output logic [15:0] out_track_label,
  output logic [5:0]  out_track_total,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gnta_pkg::*;

  localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_TRACKS);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_FDIV = 5'd1;
  localparam logic [4:0] S_FWAIT = 5'd2;
  localparam logic [4:0] S_FRD = 5'd3;
  localparam logic [4:0] S_FLAT = 5'd4;
  localparam logic [4:0] S_FAX = 5'd5;
  localparam logic [4:0] S_FM1 = 5'd6;
  localparam logic [4:0] S_FM2 = 5'd7;
  localparam logic [4:0] S_FM3 = 5'd8;
  localparam logic [4:0] S_FDW = 5'd9;
  localparam logic [4:0] S_FWB = 5'd10;
  localparam logic [4:0] S_ORD = 5'd11;
  localparam logic [4:0] S_OLAT = 5'd12;
  localparam logic [4:0] S_OSQ = 5'd13;
  localparam logic [4:0] S_OPP = 5'd14;
  localparam logic [4:0] S_OCMP = 5'd15;
  localparam logic [4:0] S_OGATE = 5'd16;
  localparam logic [4:0] S_ODEC = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  localparam logic [33:0] DISP_MAX = 34'h200000000;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] vy;
    logic [31:0] vx;
    logic [31:0] py;
    logic [31:0] px;
  } track_t;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    abs_diff = d[32] ? 32'(-d) : d[31:0];
  endfunction

  function automatic logic [31:0] abs_val(input logic [31:0] a);
    abs_val = a[31] ? -a : a;
  endfunction

  track_t mem [MAX_TRACKS];
  track_t mem_q_r;
  logic   mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  track_t mem_wdata;

  logic [4:0]  state_r, state_nxt;
  logic        kind_r, kind_nxt;
  logic [63:0] ft_r, ft_nxt;
  logic [31:0] obj_r [4];
  logic [31:0] obj_nxt [4];
  logic [15:0] gate_r [4];
  logic [15:0] gate_nxt [4];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0] nid_r, nid_nxt;
  logic [63:0] last_r, last_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [2:0]  k_r, k_nxt;
  logic        ax_r, ax_nxt;
  track_t      ent_r, ent_nxt;
  logic [63:0] q_r, q_nxt;
  logic [REM_W-1:0] r_r, r_nxt;
  logic [63:0] prod1_r, prod1_nxt;
  logic [65:0] mul_r;
  logic [32:0] mul_a, mul_b;
  logic [31:0] d_r [4];
  logic [31:0] d_nxt [4];
  logic [64:0] ps_r, ps_nxt, vs_r, vs_nxt;
  logic [129:0] sc_r, sc_nxt, bsc_r, bsc_nxt;
  logic [AW-1:0] bi_r, bi_nxt;
  logic [31:0] bd_r [4];
  logic [31:0] bd_nxt [4];
  logic [15:0] bid_r, bid_nxt;
  logic        hit_r, hit_nxt;
  logic [1:0]  res_st_r, res_st_nxt;
  logic [AW-1:0] res_slot_r, res_slot_nxt;
  logic [15:0] res_lab_r, res_lab_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_st_r, out_st_nxt;
  logic [4:0]  out_slot_r, out_slot_nxt;
  logic [15:0] out_lab_r, out_lab_nxt;
  logic [5:0]  out_tot_r, out_tot_nxt;

  div_req_t    div_req;
  logic [63:0] div_num;
  logic        div_done;
  logic [63:0] div_quot;
  logic [REM_W-1:0] div_rem;

  logic [31:0] ax_p, ax_v, ax_mag;
  logic [33:0] disp;
  logic [35:0] np_wide;
  logic [31:0] np;
  logic [63:0] disp_sum;
  logic [AW+4:0] slot_wide;
  logic [CW+5:0] tot_wide;
  logic [39:0] gate_lhs;

  gnta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= 66'(mul_a) * 66'(mul_b);
  end

  always_comb begin
    ax_p = ax_r ? ent_r.py : ent_r.px;
    ax_v = ax_r ? ent_r.vy : ent_r.vx;
    ax_mag = abs_val(ax_v);
    disp_sum = prod1_r + div_quot;
    if (state_r == S_FDW) begin
      disp = (disp_sum > 64'(DISP_MAX)) ? DISP_MAX : disp_sum[33:0];
    end else begin
      disp = DISP_MAX;
    end
    if (ax_v[31]) begin
      np_wide = {{4{ax_p[31]}}, ax_p} - 36'(disp);
    end else begin
      np_wide = {{4{ax_p[31]}}, ax_p} + 36'(disp);
    end
    if (!np_wide[35] && (np_wide[34:31] != 4'd0)) begin
      np = 32'h7fffffff;
    end else if (np_wide[35] && (np_wide[34:31] != 4'hf)) begin
      np = 32'h80000000;
    end else begin
      np = np_wide[31:0];
    end
    gate_lhs = {bd_r[k_r[1:0] - 2'd1], 8'd0};
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    ft_nxt = ft_r;
    obj_nxt = obj_r;
    gate_nxt = gate_r;
    cnt_nxt = cnt_r;
    nid_nxt = nid_r;
    last_nxt = last_r;
    i_nxt = i_r;
    k_nxt = k_r;
    ax_nxt = ax_r;
    ent_nxt = ent_r;
    q_nxt = q_r;
    r_nxt = r_r;
    prod1_nxt = prod1_r;
    d_nxt = d_r;
    ps_nxt = ps_r;
    vs_nxt = vs_r;
    sc_nxt = sc_r;
    bsc_nxt = bsc_r;
    bi_nxt = bi_r;
    bd_nxt = bd_r;
    bid_nxt = bid_r;
    hit_nxt = hit_r;
    res_st_nxt = res_st_r;
    res_slot_nxt = res_slot_r;
    res_lab_nxt = res_lab_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_st_nxt = out_st_r;
    out_slot_nxt = out_slot_r;
    out_lab_nxt = out_lab_r;
    out_tot_nxt = out_tot_r;
    mem_re = 1'b0;
    mem_we = 1'b0;
    mem_raddr = i_r[AW-1:0];
    mem_waddr = i_r[AW-1:0];
    mem_wdata = ent_r;
    mul_a = '0;
    mul_b = '0;
    div_req = '0;
    div_num = '0;
    slot_wide = (AW+5)'(res_slot_r);
    tot_wide = (CW+6)'(cnt_r);

    if (cfg_we) begin
      gate_nxt[cfg_index] = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          ft_nxt = in_frame_time;
          obj_nxt[0] = in_pos_x;
          obj_nxt[1] = in_pos_y;
          obj_nxt[2] = in_vel_x;
          obj_nxt[3] = in_vel_y;
          i_nxt = '0;
          hit_nxt = 1'b0;
          if (!in_kind) begin
            state_nxt = S_FDIV;
          end else if (cnt_r == '0) begin
            state_nxt = S_ODEC;
          end else begin
            state_nxt = S_ORD;
          end
        end
      end
      S_FDIV: begin
        div_req.start = 1'b1;
        div_num = ft_r - last_r;
        state_nxt = S_FWAIT;
      end
      S_FWAIT: begin
        if (div_done) begin
          q_nxt = div_quot;
          r_nxt = div_rem;
          last_nxt = ft_r;
          res_st_nxt = ST_FRAME;
          res_slot_nxt = '0;
          res_lab_nxt = '0;
          state_nxt = (cnt_r == '0) ? S_DONE : S_FRD;
        end
      end
      S_FRD: begin
        mem_re = 1'b1;
        state_nxt = S_FLAT;
      end
      S_FLAT: begin
        ent_nxt = mem_q_r;
        ax_nxt = 1'b0;
        state_nxt = S_FAX;
      end
      S_FAX: begin
        if (ax_mag == '0 || q_r[63:32] != '0) begin
          if (ax_mag != '0) begin
            if (ax_r) ent_nxt.py = np;
            else ent_nxt.px = np;
          end
          ax_nxt = 1'b1;
          state_nxt = ax_r ? S_FWB : S_FAX;
        end else begin
          state_nxt = S_FM1;
        end
      end
      S_FM1: begin
        mul_a = 33'(q_r[31:0]);
        mul_b = 33'(ax_mag);
        state_nxt = S_FM2;
      end
      S_FM2: begin
        prod1_nxt = mul_r[63:0];
        mul_a = 33'(r_r);
        mul_b = 33'(ax_mag);
        state_nxt = S_FM3;
      end
      S_FM3: begin
        div_req.start = 1'b1;
        div_req.short_mode = 1'b1;
        div_num = mul_r[63:0] + 64'(DT_HALF);
        state_nxt = S_FDW;
      end
      S_FDW: begin
        if (div_done) begin
          if (ax_r) ent_nxt.py = np;
          else ent_nxt.px = np;
          ax_nxt = 1'b1;
          state_nxt = ax_r ? S_FWB : S_FAX;
        end
      end
      S_FWB: begin
        mem_we = 1'b1;
        i_nxt = i_r + 1'b1;
        state_nxt = (i_r + 1'b1 == cnt_r) ? S_DONE : S_FRD;
      end
      S_ORD: begin
        mem_re = 1'b1;
        state_nxt = S_OLAT;
      end
      S_OLAT: begin
        ent_nxt = mem_q_r;
        d_nxt[0] = abs_diff(obj_r[0], mem_q_r.px);
        d_nxt[1] = abs_diff(obj_r[1], mem_q_r.py);
        d_nxt[2] = abs_diff(obj_r[2], mem_q_r.vx);
        d_nxt[3] = abs_diff(obj_r[3], mem_q_r.vy);
        k_nxt = '0;
        state_nxt = S_OSQ;
      end
      S_OSQ: begin
        if (k_r != 3'd4) begin
          mul_a = 33'(d_r[k_r[1:0]]);
          mul_b = 33'(d_r[k_r[1:0]]);
        end
        case (k_r)
          3'd1: ps_nxt = mul_r[64:0];
          3'd2: ps_nxt = ps_r + mul_r[64:0];
          3'd3: vs_nxt = mul_r[64:0];
          3'd4: vs_nxt = vs_r + mul_r[64:0];
          default: ;
        endcase
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd4) begin
          k_nxt = '0;
          state_nxt = S_OPP;
        end
      end
      S_OPP: begin
        case (k_r)
          3'd0: begin
            mul_a = 33'(ps_r[31:0]);
            mul_b = 33'(vs_r[31:0]);
          end
          3'd1: begin
            mul_a = 33'(ps_r[31:0]);
            mul_b = vs_r[64:32];
            sc_nxt = 130'(mul_r);
          end
          3'd2: begin
            mul_a = ps_r[64:32];
            mul_b = 33'(vs_r[31:0]);
            sc_nxt = sc_r + (130'(mul_r) << 32);
          end
          3'd3: begin
            mul_a = ps_r[64:32];
            mul_b = vs_r[64:32];
            sc_nxt = sc_r + (130'(mul_r) << 32);
          end
          default: sc_nxt = sc_r + (130'(mul_r) << 64);
        endcase
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd4) begin
          k_nxt = '0;
          state_nxt = S_OCMP;
        end
      end
      S_OCMP: begin
        if (i_r == '0 || sc_r < bsc_r) begin
          bsc_nxt = sc_r;
          bi_nxt = i_r[AW-1:0];
          bd_nxt = d_r;
          bid_nxt = ent_r.id;
        end
        i_nxt = i_r + 1'b1;
        k_nxt = '0;
        hit_nxt = 1'b1;
        state_nxt = (i_r + 1'b1 == cnt_r) ? S_OGATE : S_ORD;
      end
      S_OGATE: begin
        if (k_r != 3'd4) begin
          mul_a = 33'(gate_r[k_r[1:0]]);
          mul_b = 33'(abs_val(obj_r[k_r[1:0]]));
        end
        if (k_r != 3'd0 && 66'(gate_lhs) > mul_r) begin
          hit_nxt = 1'b0;
        end
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd4) begin
          state_nxt = S_ODEC;
        end
      end
      S_ODEC: begin
        mem_wdata = {16'd0, obj_r[3], obj_r[2], obj_r[1], obj_r[0]};
        if (hit_r) begin
          mem_we = 1'b1;
          mem_waddr = bi_r;
          mem_wdata.id = bid_r;
          res_st_nxt = ST_UPDATE;
          res_slot_nxt = bi_r;
          res_lab_nxt = bid_r;
        end else if (cnt_r < MAXC) begin
          mem_we = 1'b1;
          mem_waddr = cnt_r[AW-1:0];
          mem_wdata.id = nid_r;
          nid_nxt = nid_r + 16'd1;
          cnt_nxt = cnt_r + 1'b1;
          res_st_nxt = ST_CREATE;
          res_slot_nxt = cnt_r[AW-1:0];
          res_lab_nxt = nid_r;
        end else begin
          res_st_nxt = ST_DROP;
          res_slot_nxt = '0;
          res_lab_nxt = '0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = res_st_r;
          out_slot_nxt = slot_wide[4:0];
          out_lab_nxt = res_lab_r;
          out_tot_nxt = tot_wide[5:0];
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      nid_r <= '0;
      last_r <= '0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < 4; g++) begin
        gate_r[g] <= 16'd256;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      nid_r <= nid_nxt;
      last_r <= last_nxt;
      out_valid_r <= out_valid_nxt;
      gate_r <= gate_nxt;
    end
    kind_r <= kind_nxt;
    ft_r <= ft_nxt;
    obj_r <= obj_nxt;
    i_r <= i_nxt;
    k_r <= k_nxt;
    ax_r <= ax_nxt;
    ent_r <= ent_nxt;
    q_r <= q_nxt;
    r_r <= r_nxt;
    prod1_r <= prod1_nxt;
    d_r <= d_nxt;
    ps_r <= ps_nxt;
    vs_r <= vs_nxt;
    sc_r <= sc_nxt;
    bsc_r <= bsc_nxt;
    bi_r <= bi_nxt;
    bd_r <= bd_nxt;
    bid_r <= bid_nxt;
    hit_r <= hit_nxt;
    res_st_r <= res_st_nxt;
    res_slot_r <= res_slot_nxt;
    res_lab_r <= res_lab_nxt;
    out_st_r <= out_st_nxt;
    out_slot_r <= out_slot_nxt;
    out_lab_r <= out_lab_nxt;
    out_tot_r <= out_tot_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_st_r;
  assign out_track_slot = out_slot_r;
  assign out_track_label = out_lab_r;
  assign out_track_total = out_tot_r;

endmodule

[sv/gnta_div.sv]
module gnta_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gnta_pkg::div_req_t req,
  input  logic [63:0]       num,
  output logic              done,
  output logic [63:0]       quot,
  output logic [gnta_pkg::REM_W-1:0] rem
);
  import gnta_pkg::*;

  // Twelve quotient bits per step: the partial dividend is below 2^32 and is
  // divided by a reciprocal multiplication, exact over that range.
  localparam logic [32:0] RECIP = 33'd4503599628;

  logic             busy_r, busy_nxt;
  logic             phase_r, phase_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [71:0]      sh_r, sh_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [31:0]      part;
  logic [11:0]      digit;
  logic [31:0]      rem_wide;

  always_comb begin
    busy_nxt = busy_r;
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    sh_nxt = sh_r;
    prod_nxt = prod_r;
    part = {rem_r, sh_r[71:60]};
    digit = prod_r[63:52];
    rem_wide = part - 32'(digit) * 32'(DT_SCALE);
    if (req.start) begin
      busy_nxt = 1'b1;
      phase_nxt = 1'b0;
      rem_nxt = '0;
      if (req.short_mode) begin
        sh_nxt = {num[59:0], 12'd0};
        cnt_nxt = 3'd5;
      end else begin
        sh_nxt = {8'd0, num};
        cnt_nxt = 3'd6;
      end
    end else if (busy_r) begin
      if (!phase_r) begin
        prod_nxt = 64'(part) * 64'(RECIP);
        phase_nxt = 1'b1;
      end else begin
        rem_nxt = rem_wide[REM_W-1:0];
        sh_nxt = {sh_r[59:0], digit};
        cnt_nxt = cnt_r - 3'd1;
        phase_nxt = 1'b0;
        if (cnt_r == 3'd1) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      phase_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r <= sh_nxt;
    prod_r <= prod_nxt;
  end

  assign done = !busy_r;
  assign quot = sh_r[63:0];
  assign rem = rem_r;

endmodule

[dv/tb.sv]
module tb;
  import gnta_pkg::*;

  localparam int NUM_SLOTS = 32;
  localparam longint CYCLE_LIMIT = 40000000;
  localparam bit KIND_FRAME = 1'b0;
  localparam bit KIND_OBJECT = 1'b1;
  localparam logic [1:0] REG_GATE_X = 2'd0;
  localparam logic [1:0] REG_GATE_Y = 2'd1;
  localparam logic [1:0] REG_GATE_VX = 2'd2;
  localparam logic [1:0] REG_GATE_VY = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] slot;
    logic [15:0] label;
    logic [5:0] total;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [63:0] in_frame_time = '0;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_vel_x = '0;
  logic signed [31:0] in_vel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [4:0] out_track_slot;
  logic [15:0] out_track_label;
  logic [5:0] out_track_total;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  gated_nearest_track_association u_top (.*);

  // Mirror of the track table and gate registers.
  logic [15:0] gate_factor [4];
  logic [31:0] trk_px [NUM_SLOTS];
  logic [31:0] trk_py [NUM_SLOTS];
  logic [31:0] trk_vx [NUM_SLOTS];
  logic [31:0] trk_vy [NUM_SLOTS];
  logic [15:0] trk_label [NUM_SLOTS];
  int track_count = 0;
  logic [15:0] next_label = '0;
  logic [63:0] prev_frame_time = '0;

  verdict_t pending_verdicts [$];
  int mismatches = 0;
  longint cycles = 0;
  int burst_left = 0;
  int hold_request = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("gated_nearest_track_association regression: fail");
      $finish;
    end
  end

  function automatic longint unsigned abs_diff(longint a, longint b);
    return (a >= b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic logic [31:0] moved(logic [31:0] p, logic [31:0] v,
                                        longint unsigned dt);
    longint vs;
    longint np;
    longint unsigned mag, q, r, disp;
    vs = $signed(v);
    mag = (vs < 0) ? -vs : vs;
    if (mag == 0) return p;
    q = dt / DT_SCALE;
    r = dt % DT_SCALE;
    if (q >= 64'h1_0000_0000) disp = 64'h2_0000_0000;
    else begin
      disp = q * mag + (r * mag + DT_HALF) / DT_SCALE;
      if (disp > 64'h2_0000_0000) disp = 64'h2_0000_0000;
    end
    np = $signed(p);
    np = (vs < 0) ? np - longint'(disp) : np + longint'(disp);
    if (np > 64'sd2147483647) np = 64'sd2147483647;
    if (np < -64'sd2147483648) np = -64'sd2147483648;
    return np[31:0];
  endfunction

  function automatic bit within_gate(longint unsigned d, longint obj, logic [15:0] g);
    longint unsigned mag;
    mag = (obj < 0) ? -obj : obj;
    return (d << 8) <= longint'(g) * mag;
  endfunction

  function automatic verdict_t associate(bit kind, logic [63:0] t, logic [31:0] px,
                                         logic [31:0] py, logic [31:0] vx,
                                         logic [31:0] vy);
    verdict_t res;
    bit [65:0] ax, ay, pd, vd;
    bit [131:0] score, best_score, wide_pd;
    longint ox, oy, ovx, ovy;
    int best;
    bit hit;
    res = '0;
    if (kind == KIND_FRAME) begin
      for (int i = 0; i < track_count; i++) begin
        trk_px[i] = moved(trk_px[i], trk_vx[i], t - prev_frame_time);
        trk_py[i] = moved(trk_py[i], trk_vy[i], t - prev_frame_time);
      end
      prev_frame_time = t;
      res.status = ST_FRAME;
    end else begin
      ox = $signed(px);
      oy = $signed(py);
      ovx = $signed(vx);
      ovy = $signed(vy);
      best = 0;
      hit = 1'b0;
      best_score = '0;
      for (int i = 0; i < track_count; i++) begin
        ax = abs_diff(ox, $signed(trk_px[i]));
        ay = abs_diff(oy, $signed(trk_py[i]));
        pd = ax * ax + ay * ay;
        ax = abs_diff(ovx, $signed(trk_vx[i]));
        ay = abs_diff(ovy, $signed(trk_vy[i]));
        vd = ax * ax + ay * ay;
        wide_pd = pd;
        score = wide_pd * vd;
        if (i == 0 || score < best_score) begin
          best_score = score;
          best = i;
        end
      end
      if (track_count > 0) begin
        hit = within_gate(abs_diff(ox, $signed(trk_px[best])), ox, gate_factor[REG_GATE_X])
           && within_gate(abs_diff(oy, $signed(trk_py[best])), oy, gate_factor[REG_GATE_Y])
           && within_gate(abs_diff(ovx, $signed(trk_vx[best])), ovx, gate_factor[REG_GATE_VX])
           && within_gate(abs_diff(ovy, $signed(trk_vy[best])), ovy,
                          gate_factor[REG_GATE_VY]);
      end
      if (hit) res.status = ST_UPDATE;
      else if (track_count < NUM_SLOTS) begin
        best = track_count;
        trk_label[best] = next_label;
        next_label = next_label + 16'd1;
        track_count++;
        res.status = ST_CREATE;
      end else res.status = ST_DROP;
      if (res.status != ST_DROP) begin
        trk_px[best] = px;
        trk_py[best] = py;
        trk_vx[best] = vx;
        trk_vy[best] = vy;
        res.slot = best[4:0];
        res.label = trk_label[best];
      end
    end
    res.total = track_count[5:0];
    return res;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_status !== want.status || out_track_slot !== want.slot ||
            out_track_label !== want.label || out_track_total !== want.total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d slot %0d/%0d label %0d/%0d total %0d/%0d",
                     want.status, out_status, want.slot, out_track_slot,
                     want.label, out_track_label, want.total, out_track_total);
        end
      end
    end
  end

  // The receiver stalls in patterns that follow the cycle count.
  always @(negedge clk) begin
    int mode;
    if (hold_request > 0) begin
      out_stall <= 1'b1;
      hold_request <= hold_request - 1;
    end else begin
      mode = (cycles / 300) % 4;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic send_item(bit kind, logic [63:0] t, logic [31:0] px, logic [31:0] py,
                           logic [31:0] vx, logic [31:0] vy);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_frame_time <= t;
    in_pos_x <= px;
    in_pos_y <= py;
    in_vel_x <= vx;
    in_vel_y <= vy;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(associate(kind, t, px, py, vx, vy));
    burst_left--;
  endtask

  task automatic send_frame(logic [63:0] t);
    send_item(KIND_FRAME, t, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_object(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                             logic [31:0] vy);
    send_item(KIND_OBJECT, $urandom(), px, py, vx, vy);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (pending_verdicts.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_gate(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    gate_factor[idx] = value;
  endtask

  function automatic logic [31:0] jitter(logic [31:0] base);
    int shift;
    logic [31:0] d;
    shift = $urandom_range(3, 14);
    d = $signed(base) >>> shift;
    if ($urandom_range(0, 1)) d = -d;
    return base + d;
  endfunction

  task automatic send_near_track(bit exact);
    int k;
    k = $urandom_range(0, track_count - 1);
    if (exact) send_object(trk_px[k], trk_py[k], trk_vx[k], trk_vy[k]);
    else send_object(jitter(trk_px[k]), jitter(trk_py[k]), jitter(trk_vx[k]),
                     jitter(trk_vy[k]));
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'd0;
      2: return {$urandom_range(0, 1) ? 12'hfff : 12'h000, 20'($urandom)};
      default: return 32'($signed(24'($urandom)));
    endcase
  endfunction

  function automatic logic [63:0] rnd_time();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return prev_frame_time - $urandom_range(1, 1000);
      2: return prev_frame_time;
      default: return prev_frame_time + $urandom_range(1, 5000000);
    endcase
  endfunction

  task automatic test_empty_and_extremes();
    send_frame(64'd1000);
    send_object(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_object(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_object(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_object(32'd0, 32'd0, 32'd0, 32'd0);
    send_object(32'd0, 32'd0, 32'd0, 32'd0);
    send_object(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'hffff_8000);
    send_object(32'h0001_0100, 32'hfffe_ff00, 32'h0000_8100, 32'hffff_7f00);
    send_object(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_object(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    send_frame(64'd1500000);
    send_frame(64'd1500000);
    send_frame(64'd2000000);
    send_frame(64'd500);
    send_frame(64'hffff_ffff_ffff_ffff);
    send_frame(64'd0);
    send_object(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    drain();
  endtask

  task automatic test_gate_settings();
    logic [15:0] settings [4] = '{16'd0, 16'hffff, 16'd256, 16'd0};
    foreach (settings[s]) begin
      write_gate(REG_GATE_X, s == 3 ? 16'($urandom) : settings[s]);
      write_gate(REG_GATE_Y, s == 3 ? 16'($urandom) : settings[s]);
      write_gate(REG_GATE_VX, s == 3 ? 16'($urandom) : settings[s]);
      write_gate(REG_GATE_VY, s == 3 ? 16'($urandom) : settings[s]);
      repeat (6) send_near_track($urandom_range(0, 1));
      send_object(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
      drain();
    end
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 19))
        0, 1: send_frame(rnd_time());
        2, 3, 4, 5: send_object(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        6: send_object($urandom, $urandom, $urandom, $urandom);
        default: begin
          if (track_count == 0) send_object(rnd_coord(), rnd_coord(), rnd_coord(),
                                            rnd_coord());
          else send_near_track($urandom_range(0, 5) == 0);
        end
      endcase
    end
    drain();
  endtask

  task automatic test_random_traffic();
    write_gate(REG_GATE_X, 16'd256);
    write_gate(REG_GATE_Y, 16'd256);
    write_gate(REG_GATE_VX, 16'd256);
    write_gate(REG_GATE_VY, 16'd256);
    run_random(600);
    write_gate(REG_GATE_X, 16'($urandom_range(16, 1024)));
    write_gate(REG_GATE_Y, 16'($urandom_range(16, 1024)));
    write_gate(REG_GATE_VX, 16'($urandom_range(16, 1024)));
    write_gate(REG_GATE_VY, 16'($urandom_range(16, 1024)));
    run_random(600);
    write_gate(REG_GATE_X, 16'hffff);
    write_gate(REG_GATE_Y, 16'd0);
    write_gate(REG_GATE_VX, 16'hffff);
    write_gate(REG_GATE_VY, 16'd0);
    run_random(500);
  endtask

  task automatic test_backpressure();
    hold_request = 3000;
    burst_left = 100;
    for (int n = 0; n < 12; n++)
      if (track_count > 0) send_near_track(1'b0);
      else send_object(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    drain();
  endtask

  initial begin
    foreach (gate_factor[i]) gate_factor[i] = 16'd256;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_and_extremes();
    test_gate_settings();
    test_backpressure();
    test_random_traffic();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("gated_nearest_track_association regression: pass");
    end else begin
      $display("gated_nearest_track_association regression: fail");
    end
    $finish;
  end

endmodule
